/* hw/rtl/bba_pkg.sv */
`default_nettype none
package bba_pkg;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_REALLOC = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_BADADDR = 2'd2;

    localparam logic CFG_POOL_BASE   = 1'b0;
    localparam logic CFG_MAX_REQUEST = 1'b1;

    localparam logic [13:0] MAX_REQUEST_RESET = 14'd8192;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_A_START,
        ST_A_PROBE,
        ST_A_LOOK,
        ST_A_UP,
        ST_OFF,
        ST_RADDR,
        ST_MARK,
        ST_F_START,
        ST_F_PROBE,
        ST_F_LOOK,
        ST_FR_STEP,
        ST_FR_PROBE,
        ST_S_CHK,
        ST_S_SET,
        ST_G_PROBE,
        ST_G_LOOK,
        ST_G_OFF,
        ST_G_RADDR,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        I_HOLD,
        I_ROOT,
        I_LEFT,
        I_RIGHT,
        I_NEXT,
        I_UP,
        I_ORIG
    } iop_t;

    typedef enum logic [1:0] {
        MV_ZERO,
        MV_ONE,
        MV_CMP
    } mvsel_t;

    typedef struct packed {
        logic       load;
        logic       probe;
        iop_t       iop;
        logic       wr_en;
        logic       wr_val;
        logic       save_orig;
        logic       set_shrunk;
        logic       calc_off;
        logic       calc_raddr;
        mvsel_t     mv_sel;
        logic       raddr_from_addr;
        logic       status_en;
        logic [1:0] status_val;
        logic       push;
    } cmd_t;

    typedef struct packed {
        logic       clr_busy;
        logic       out_free;
        logic [1:0] func;
        logic       mk;
        logic       sib;
        logic       split;
        logic       i_zero;
        logic       i_odd;
        logic       fits_next;
        logic       fits_cur;
        logic       size_le_old;
        logic       too_big;
        logic       addr_bad;
        logic       at_cur;
        logic       last_level;
        logic       go_left;
        logic       shrunk;
    } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
`default_nettype none
module bba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire bba_pkg::stat_t stat,
    output bba_pkg::cmd_t      cmd
);
    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !stat.clr_busy)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.func == FUNC_ALLOC)
                begin
                    state_next = ST_A_START;
                end
                else if (stat.func == FUNC_FREE || stat.func == FUNC_REALLOC)
                begin
                    state_next = ST_F_START;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_A_START:
            begin
                state_next = stat.too_big ? ST_DONE : ST_A_PROBE;
            end
            ST_A_PROBE:
            begin
                state_next = ST_A_LOOK;
            end
            ST_A_LOOK:
            begin
                if (stat.mk && (!stat.fits_next || !stat.split))
                begin
                    state_next = ST_A_UP;
                end
                else if (stat.fits_next)
                begin
                    state_next = ST_A_PROBE;
                end
                else
                begin
                    state_next = ST_OFF;
                end
            end
            ST_A_UP:
            begin
                if (stat.i_zero)
                begin
                    state_next = (stat.func == FUNC_REALLOC) ? ST_MARK : ST_DONE;
                end
                else if (stat.i_odd)
                begin
                    state_next = ST_A_PROBE;
                end
            end
            ST_OFF:
            begin
                state_next = ST_RADDR;
            end
            ST_RADDR:
            begin
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                if (stat.i_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_F_START:
            begin
                state_next = stat.addr_bad ? ST_DONE : ST_F_PROBE;
            end
            ST_F_PROBE:
            begin
                state_next = ST_F_LOOK;
            end
            ST_F_LOOK:
            begin
                if (stat.at_cur && !stat.split)
                begin
                    if (!stat.mk)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (stat.func == FUNC_FREE)
                    begin
                        state_next = ST_FR_STEP;
                    end
                    else
                    begin
                        state_next = ST_S_CHK;
                    end
                end
                else if (stat.last_level)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_F_PROBE;
                end
            end
            ST_FR_STEP:
            begin
                state_next = (stat.i_zero || stat.sib) ? ST_DONE : ST_FR_PROBE;
            end
            ST_FR_PROBE:
            begin
                state_next = ST_FR_STEP;
            end
            ST_S_CHK:
            begin
                if (stat.fits_next)
                begin
                    state_next = ST_S_SET;
                end
                else if (stat.shrunk || stat.size_le_old || stat.too_big)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_G_PROBE;
                end
            end
            ST_S_SET:
            begin
                state_next = ST_S_CHK;
            end
            ST_G_PROBE:
            begin
                state_next = ST_G_LOOK;
            end
            ST_G_LOOK:
            begin
                if (stat.fits_cur)
                begin
                    state_next = ST_G_OFF;
                end
                else if (stat.i_zero || stat.sib)
                begin
                    state_next = ST_A_PROBE;
                end
                else
                begin
                    state_next = ST_G_PROBE;
                end
            end
            ST_G_OFF:
            begin
                state_next = ST_G_RADDR;
            end
            ST_G_RADDR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !stat.clr_busy;
                cmd.load = s_tvalid && !stat.clr_busy;
            end
            ST_DISPATCH:
            begin
                if (stat.func != FUNC_ALLOC && stat.func != FUNC_FREE
                    && stat.func != FUNC_REALLOC)
                begin
                    cmd.status_en  = 1'b1;
                    cmd.status_val = STAT_NOSPACE;
                end
            end
            ST_A_START:
            begin
                if (stat.too_big)
                begin
                    cmd.status_en  = 1'b1;
                    cmd.status_val = STAT_NOSPACE;
                end
            end
            ST_A_PROBE, ST_F_PROBE, ST_FR_PROBE, ST_G_PROBE:
            begin
                cmd.probe = 1'b1;
            end
            ST_A_LOOK:
            begin
                if (!(stat.mk && (!stat.fits_next || !stat.split)) && stat.fits_next)
                begin
                    cmd.iop = I_LEFT;
                end
            end
            ST_A_UP:
            begin
                if (stat.i_zero)
                begin
                    cmd.status_en  = 1'b1;
                    cmd.status_val = STAT_NOSPACE;
                    if (stat.func == FUNC_REALLOC)
                    begin
                        cmd.iop = I_ORIG;
                    end
                end
                else if (stat.i_odd)
                begin
                    cmd.iop = I_NEXT;
                end
                else
                begin
                    cmd.iop = I_UP;
                end
            end
            ST_OFF, ST_G_OFF:
            begin
                cmd.calc_off = 1'b1;
            end
            ST_RADDR:
            begin
                cmd.calc_raddr = 1'b1;
                cmd.mv_sel     = (stat.func == FUNC_REALLOC) ? MV_ONE : MV_ZERO;
            end
            ST_G_RADDR:
            begin
                cmd.calc_raddr = 1'b1;
                cmd.mv_sel     = MV_CMP;
            end
            ST_MARK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_val = 1'b1;
                if (!stat.i_zero)
                begin
                    cmd.iop = I_UP;
                end
            end
            ST_F_START:
            begin
                if (stat.addr_bad)
                begin
                    cmd.status_en  = 1'b1;
                    cmd.status_val = STAT_BADADDR;
                end
            end
            ST_F_LOOK:
            begin
                if (stat.at_cur && !stat.split)
                begin
                    if (!stat.mk)
                    begin
                        cmd.status_en  = 1'b1;
                        cmd.status_val = STAT_BADADDR;
                    end
                    else if (stat.func != FUNC_FREE)
                    begin
                        cmd.save_orig = 1'b1;
                    end
                end
                else if (stat.last_level)
                begin
                    cmd.status_en  = 1'b1;
                    cmd.status_val = STAT_BADADDR;
                end
                else
                begin
                    cmd.iop = stat.go_left ? I_LEFT : I_RIGHT;
                end
            end
            ST_FR_STEP:
            begin
                cmd.wr_en = 1'b1;
                if (!(stat.i_zero || stat.sib))
                begin
                    cmd.iop = I_UP;
                end
            end
            ST_S_CHK:
            begin
                if (stat.fits_next)
                begin
                    cmd.iop        = I_LEFT;
                    cmd.set_shrunk = 1'b1;
                end
                else if (stat.shrunk || stat.size_le_old)
                begin
                    cmd.raddr_from_addr = 1'b1;
                end
                else if (stat.too_big)
                begin
                    cmd.status_en  = 1'b1;
                    cmd.status_val = STAT_NOSPACE;
                end
            end
            ST_S_SET:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_val = 1'b1;
            end
            ST_G_LOOK:
            begin
                if (!stat.fits_cur)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.iop   = (stat.i_zero || stat.sib) ? I_ROOT : I_UP;
                end
            end
            ST_DONE:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/bba_datapath.sv */
`default_nettype none
module bba_datapath #(
    parameter int LEVELS        = 10,
    parameter int GRANULE_BYTES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bba_pkg::cmd_t cmd,
    output bba_pkg::stat_t     stat,
    input  wire logic [55:0]   s_tdata,
    input  wire logic [1:0]    s_tuser,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_index,
    input  wire logic [31:0]   cfg_data,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,
    output logic [1:0]         m_tuser
);
    import bba_pkg::*;

    localparam int IW   = LEVELS;
    localparam int AW   = LEVELS - 1;
    localparam int PD   = (1 << AW) - 1;
    localparam int LW   = $clog2(LEVELS + 1);
    localparam int POOL = GRANULE_BYTES * (1 << (LEVELS - 1));
    localparam int PW   = $clog2(POOL + 1);
    localparam int CW   = (PW > 25) ? PW : 25;
    localparam logic [CW-1:0] GRAN = CW'(GRANULE_BYTES);

    function automatic logic [CW-1:0] bsize(input logic [LW-1:0] lv);
        logic [CW-1:0] r;
        if (int'(lv) >= LEVELS)
        begin
            r = '0;
        end
        else
        begin
            r = GRAN << (LEVELS - 1 - int'(lv));
        end
        return r;
    endfunction

    // mark store: left and right child marks indexed by parent node
    logic left_mem  [0:(1<<AW)-1];
    logic right_mem [0:(1<<AW)-1];

    logic          root_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [31:0]   base_reg;
    logic [13:0]   maxreq_reg;
    logic          m_tvalid_reg;

    logic [1:0]    func_reg;
    logic [24:0]   size_reg;
    logic [31:0]   addr_reg;
    logic [PW-1:0] toff_reg;
    logic          bad_reg;
    logic [IW-1:0] i_reg;
    logic [LW-1:0] b_reg;
    logic [PW-1:0] cur_reg;
    logic [IW-1:0] orig_reg;
    logic [CW-1:0] old_reg;
    logic          shrunk_reg;
    logic [PW-1:0] off_reg;
    logic [31:0]   raddr_reg;
    logic          move_reg;
    logic [1:0]    status_reg;
    logic          lc_q, rc_q, ls_q, rs_q;
    logic [47:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    logic [LW-1:0] b1;
    logic [CW-1:0] bs_next, bs_cur, size_ext;
    logic [PW-1:0] half_p;
    logic [IW-1:0] i_m1;
    logic [AW-1:0] par_addr;
    logic          i_zero;
    logic          last_level;
    logic [31:0]   full_off;
    logic [24:0]   size_in;
    logic [IW-1:0] lvl_first, node_pos, leaf_idx;
    logic [LW-1:0] shamt;
    logic [PW-1:0] off_val;
    logic [31:0]   raddr_val;
    logic          wr_left, wr_right, wr_root;

    assign b1         = b_reg + LW'(1);
    assign bs_next    = bsize(b1);
    assign bs_cur     = bsize(b_reg);
    assign size_ext   = CW'(size_reg);
    assign half_p     = PW'(bs_next);
    assign i_m1       = i_reg - IW'(1);
    assign par_addr   = i_m1[IW-1:1];
    assign i_zero     = (i_reg == '0);
    assign last_level = (b1 >= LW'(LEVELS));
    assign full_off   = s_tdata[55:24] - base_reg;
    assign size_in    = (s_tdata[23:0] == 24'd0) ? 25'd1 : {1'b0, s_tdata[23:0]};

    assign lvl_first  = (IW'(1) << b_reg) - IW'(1);
    assign node_pos   = i_reg - lvl_first;
    assign shamt      = LW'(LEVELS - 1) - b_reg;
    assign leaf_idx   = node_pos << shamt;
    assign off_val    = PW'(leaf_idx) * PW'(GRANULE_BYTES);
    assign raddr_val  = base_reg + 32'(off_reg);

    assign wr_root    = cmd.wr_en && i_zero;
    assign wr_left    = cmd.wr_en && !i_zero && i_reg[0];
    assign wr_right   = cmd.wr_en && !i_zero && !i_reg[0];

    always_comb
    begin
        stat.clr_busy    = clr_busy_reg;
        stat.out_free    = !m_tvalid_reg || m_tready;
        stat.func        = func_reg;
        stat.mk          = i_zero ? root_reg : (i_reg[0] ? ls_q : rs_q);
        stat.sib         = i_reg[0] ? rs_q : ls_q;
        stat.split       = !last_level && (lc_q || rc_q);
        stat.i_zero      = i_zero;
        stat.i_odd       = i_reg[0];
        stat.fits_next   = size_ext <= bs_next;
        stat.fits_cur    = bs_cur >= size_ext;
        stat.size_le_old = size_ext <= old_reg;
        stat.too_big     = (size_reg > 25'(maxreq_reg)) || (size_ext > CW'(POOL));
        stat.addr_bad    = bad_reg;
        stat.at_cur      = (toff_reg == cur_reg);
        stat.last_level  = last_level;
        stat.go_left     = {1'b0, toff_reg} < ({1'b0, cur_reg} + {1'b0, half_p});
        stat.shrunk      = shrunk_reg;
    end

    // control state, config and clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg     <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            base_reg     <= '0;
            maxreq_reg   <= MAX_REQUEST_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == AW'(PD - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
            if (wr_root)
            begin
                root_reg <= cmd.wr_val;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_POOL_BASE:   base_reg   <= cfg_data;
                    CFG_MAX_REQUEST: maxreq_reg <= cfg_data[13:0];
                    default:         base_reg   <= base_reg;
                endcase
            end
            if (cmd.push)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            left_mem[clr_addr_reg]  <= 1'b0;
            right_mem[clr_addr_reg] <= 1'b0;
        end
        else
        begin
            if (wr_left)
            begin
                left_mem[par_addr] <= cmd.wr_val;
            end
            if (wr_right)
            begin
                right_mem[par_addr] <= cmd.wr_val;
            end
        end
        if (cmd.probe)
        begin
            lc_q <= left_mem[i_reg[AW-1:0]];
            rc_q <= right_mem[i_reg[AW-1:0]];
            ls_q <= left_mem[par_addr];
            rs_q <= right_mem[par_addr];
        end
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= s_tuser;
            size_reg   <= size_in;
            addr_reg   <= s_tdata[55:24];
            toff_reg   <= full_off[PW-1:0];
            bad_reg    <= (s_tdata[55:24] < base_reg) || (full_off >= 32'(POOL));
            i_reg      <= '0;
            b_reg      <= '0;
            cur_reg    <= '0;
            old_reg    <= '0;
            shrunk_reg <= 1'b0;
            raddr_reg  <= '0;
            move_reg   <= 1'b0;
            status_reg <= STAT_OK;
        end
        else
        begin
            case (cmd.iop)
                I_ROOT:
                begin
                    i_reg   <= '0;
                    b_reg   <= '0;
                    cur_reg <= '0;
                end
                I_LEFT:
                begin
                    i_reg <= {i_reg[IW-2:0], 1'b1};
                    b_reg <= b1;
                end
                I_RIGHT:
                begin
                    i_reg   <= {i_reg[IW-2:0], 1'b0} + IW'(2);
                    b_reg   <= b1;
                    cur_reg <= cur_reg + half_p;
                end
                I_NEXT:
                begin
                    i_reg <= i_reg + IW'(1);
                end
                I_UP:
                begin
                    i_reg <= {1'b0, i_m1[IW-1:1]};
                    b_reg <= b_reg - LW'(1);
                end
                I_ORIG:
                begin
                    i_reg <= orig_reg;
                end
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase
            if (cmd.save_orig)
            begin
                orig_reg <= i_reg;
                old_reg  <= bs_cur;
            end
            if (cmd.set_shrunk)
            begin
                shrunk_reg <= 1'b1;
            end
            if (cmd.calc_off)
            begin
                off_reg <= off_val;
            end
            if (cmd.calc_raddr)
            begin
                raddr_reg <= raddr_val;
                case (cmd.mv_sel)
                    MV_ONE:  move_reg <= 1'b1;
                    MV_CMP:  move_reg <= (raddr_val != addr_reg);
                    default: move_reg <= 1'b0;
                endcase
            end
            if (cmd.raddr_from_addr)
            begin
                raddr_reg <= addr_reg;
            end
            if (cmd.status_en)
            begin
                status_reg <= cmd.status_val;
            end
        end
        if (cmd.push)
        begin
            m_tdata_reg <= {1'b0, move_reg, old_reg[13:0], raddr_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule
`default_nettype wire

/* hw/rtl/buddy_block_allocator_core.sv */
`default_nettype none
// channel   direction  beat contents
// s_*       in         tdata: req_size[23:0], address[55:24]; tuser: func[1:0]
// m_*       out        tdata: result_address[31:0], old_size[45:32], move_needed[46]
//                      tuser: status[1:0]
// cfg_*     in         cfg_index: 0 pool_base, 1 max_request; cfg_data: value
//
// one request at a time; a probed tree node takes a mark read and then a decision,
// a backtrack step moves up or across, a merge step clears a mark and then reads the
// marks one level up, and marking a new path writes one level at a time on the way up.
// how long an allocate runs depends on how far it backtracks.
// after reset the mark store is cleared entry by entry while s_tready is low.
// a finished result sits in the output register while the next request is taken;
// the sequencer only stalls at its end if that register is still full.
module buddy_block_allocator_core #(
    parameter int LEVELS        = 10,
    parameter int GRANULE_BYTES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // req_size, address
    input  wire logic [1:0]  s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // result_address, old_size, move_needed, zero pad
    output logic [1:0]       m_tuser,   // status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import bba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath #(
        .LEVELS        (LEVELS),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
